### src/bmcu_pkg.sv
// ----------------------------------------------------------------------------
// Byte memory control unit package
// Types, codes and sizes shared by the control unit's files.
// ----------------------------------------------------------------------------
package bmcu_pkg;

   localparam int MemDepthDefault = 2048;
   localparam int IoDepthDefault  = 32;

   localparam int AddrWidth = 11;
   localparam int WordWidth = 16;
   localparam int IoSelWidth = 5;

   // Request function codes.
   localparam logic [1:0] FUNC_LOAD_MEM = 2'd0;
   localparam logic [1:0] FUNC_STEP     = 2'd1;
   localparam logic [1:0] FUNC_WRITE_IO = 2'd2;
   localparam logic [1:0] FUNC_READ_IO  = 2'd3;

   // Instruction opcodes.
   localparam logic [4:0] OP_WM  = 5'h01;
   localparam logic [4:0] OP_RM  = 5'h02;
   localparam logic [4:0] OP_BR  = 5'h03;
   localparam logic [4:0] OP_RIO = 5'h04;
   localparam logic [4:0] OP_WIO = 5'h05;
   localparam logic [4:0] OP_WB  = 5'h06;
   localparam logic [4:0] OP_WIB = 5'h07;
   localparam logic [4:0] OP_EOP = 5'h1F;

   // Response status codes.
   localparam logic [2:0] STAT_ACCESS = 3'd0;
   localparam logic [2:0] STAT_EXEC   = 3'd1;
   localparam logic [2:0] STAT_END    = 3'd2;
   localparam logic [2:0] STAT_BADOP  = 3'd3;
   localparam logic [2:0] STAT_HALTED = 3'd4;

   typedef struct packed {
      logic [1:0]           func;
      logic [AddrWidth-1:0] addr;
      logic [7:0]           data;
   } bmcu_req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [AddrWidth-1:0] pc_next;
      logic [WordWidth-1:0] instr_word;
      logic [7:0]           mbr_value;
      logic [7:0]           iobr_value;
      logic [7:0]           io_read;
   } bmcu_rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_ACCEPT = 4'b0010,
      S_FETCH  = 4'b0100,
      S_DATA   = 4'b1000
   } bmcu_state_type;

endpackage

### src/byte_memory_control_unit_core.sv
// ----------------------------------------------------------------------------
// Byte memory control unit core
// Byte-wide main memory, IO buffer and a one-instruction-per-step executor.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel (valid/ready); each carries a function
//   code, an address and a data byte. Every request produces exactly one
//   response on the rsp_ channel, in request order.
//   Memory loads, IO writes and IO reads complete in the transfer cycle; the
//   response is valid on the next cycle, and such requests can be taken one
//   per cycle while rsp_ready is high.
//   A step request fetches the instruction from the synchronous main memory
//   (both bytes on the two read ports at once) and registers its response in
//   the fetch state, or in the data state for a read-memory instruction, which
//   needs a second memory read; a step while halted is answered like a memory
//   load, with the halted status. A new request is taken as soon as a step's
//   response is registered. After reset the main memory is swept to zero, one
//   byte per cycle, from address 0 to MEM_DEPTH-1; no request is taken during
//   the sweep. The IO buffer and the control registers are cleared at once.
//   The response register holds its value while rsp_ready is low. A new
//   request is taken while a response waits only if it is taken that cycle.
// ----------------------------------------------------------------------------
module byte_memory_control_unit_core #(
   parameter int MEM_DEPTH = bmcu_pkg::MemDepthDefault,
   parameter int IO_DEPTH  = bmcu_pkg::IoDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bmcu_pkg::bmcu_req_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bmcu_pkg::bmcu_rsp_type rsp_item
);

   localparam int MemAw = $clog2(MEM_DEPTH);
   localparam int IoAw  = $clog2(IO_DEPTH);
   localparam int MemRw = bmcu_pkg::AddrWidth + 3;
   localparam int IoRw  = bmcu_pkg::IoSelWidth + 2;
   localparam int AW    = bmcu_pkg::AddrWidth;

   // Addresses may exceed the memory size; a value below eight times the
   // depth is reduced by three conditional subtractions.
   function automatic logic [MemAw-1:0] mem_index(input logic [AW-1:0] a);
      logic [MemRw-1:0] v;
      v = MemRw'(a);
      if (v >= MemRw'(4 * MEM_DEPTH)) v = v - MemRw'(4 * MEM_DEPTH);
      if (v >= MemRw'(2 * MEM_DEPTH)) v = v - MemRw'(2 * MEM_DEPTH);
      if (v >= MemRw'(MEM_DEPTH))     v = v - MemRw'(MEM_DEPTH);
      return v[MemAw-1:0];
   endfunction

   // IO addresses use the low five bits, reduced to the IO buffer size.
   function automatic logic [IoAw-1:0] io_index(input logic [AW-1:0] a);
      logic [IoRw-1:0] v;
      v = IoRw'(a[bmcu_pkg::IoSelWidth-1:0]);
      if (v >= IoRw'(2 * IO_DEPTH)) v = v - IoRw'(2 * IO_DEPTH);
      if (v >= IoRw'(IO_DEPTH))     v = v - IoRw'(IO_DEPTH);
      return v[IoAw-1:0];
   endfunction

   bmcu_pkg::bmcu_state_type state_ff, state_in;
   logic [MemAw-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]           pc_ff, pc_in;
   logic [7:0]              mbr_ff, mbr_in;
   logic [7:0]              iobr_ff, iobr_in;
   logic                    halted_ff, halted_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bmcu_pkg::bmcu_rsp_type  rsp_ff, rsp_in;
   logic [bmcu_pkg::WordWidth-1:0] word_ff, word_in;

   // Main memory with one write port and two registered read ports.
   logic [7:0]       mem [MEM_DEPTH];
   logic             mem_we;
   logic [MemAw-1:0] mem_wa;
   logic [7:0]       mem_wd;
   logic [MemAw-1:0] mem_ra;
   logic [MemAw-1:0] mem_rb;
   logic [7:0]       rd_a_ff;
   logic [7:0]       rd_b_ff;

   // IO buffer in flip-flops, cleared by reset.
   logic [7:0]       io_ff [IO_DEPTH];
   logic             io_we;
   logic [IoAw-1:0]  io_wa;
   logic [7:0]       io_wd;
   logic [IoAw-1:0]  io_ra;
   logic [7:0]       io_rd;

   logic                           out_free;
   logic                           req_fire;
   logic [bmcu_pkg::WordWidth-1:0] fetch_word;
   logic [4:0]                     opcode;
   logic [AW-1:0]                  operand;
   logic [AW-1:0]                  pc_plus1;
   logic [AW-1:0]                  pc_plus2;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == bmcu_pkg::S_ACCEPT) && out_free;
   assign req_fire   = req_valid && req_ready;
   assign fetch_word = {rd_a_ff, rd_b_ff};
   assign opcode     = fetch_word[bmcu_pkg::WordWidth-1:AW];
   assign operand    = fetch_word[AW-1:0];
   assign pc_plus1   = pc_ff + AW'(1);
   assign pc_plus2   = pc_ff + AW'(2);
   assign io_rd      = io_ff[io_ra];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      pc_in        = pc_ff;
      mbr_in       = mbr_ff;
      iobr_in      = iobr_ff;
      halted_in    = halted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      word_in      = word_ff;
      mem_we       = 1'b0;
      mem_wa       = mem_index(req_item.addr);
      mem_wd       = req_item.data;
      mem_ra       = mem_index(pc_ff);
      mem_rb       = mem_index(pc_plus1);
      io_we        = 1'b0;
      io_wa        = io_index(req_item.addr);
      io_wd        = req_item.data;
      io_ra        = io_index(req_item.addr);

      unique case (state_ff)
         bmcu_pkg::S_CLEAR: begin
            // Zero sweep of the main memory after reset.
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = 8'd0;
            clr_cnt_in = clr_cnt_ff + MemAw'(1);
            if (clr_cnt_ff == MemAw'(MEM_DEPTH - 1)) begin
               state_in = bmcu_pkg::S_ACCEPT;
            end
         end
         bmcu_pkg::S_ACCEPT: begin
            if (req_fire) begin
               rsp_in.status     = bmcu_pkg::STAT_ACCESS;
               rsp_in.pc_next    = pc_ff;
               rsp_in.instr_word = '0;
               rsp_in.mbr_value  = mbr_ff;
               rsp_in.iobr_value = iobr_ff;
               rsp_in.io_read    = 8'd0;
               rsp_valid_in      = 1'b1;
               unique case (req_item.func)
                  bmcu_pkg::FUNC_LOAD_MEM: begin
                     mem_we = 1'b1;
                  end
                  bmcu_pkg::FUNC_WRITE_IO: begin
                     io_we = 1'b1;
                  end
                  bmcu_pkg::FUNC_READ_IO: begin
                     rsp_in.io_read = io_rd;
                  end
                  bmcu_pkg::FUNC_STEP: begin
                     if (halted_ff) begin
                        rsp_in.status = bmcu_pkg::STAT_HALTED;
                     end else begin
                        // Both instruction bytes are read at this edge.
                        rsp_valid_in = 1'b0;
                        state_in     = bmcu_pkg::S_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bmcu_pkg::S_FETCH: begin
            pc_in   = pc_plus2;
            word_in = fetch_word;
            rsp_in.status = bmcu_pkg::STAT_EXEC;
            io_ra   = io_index(operand);
            mem_wa  = mem_index(operand);
            mem_wd  = mbr_ff;
            io_wa   = io_index(operand);
            io_wd   = iobr_ff;
            state_in     = bmcu_pkg::S_ACCEPT;
            rsp_valid_in = 1'b1;
            unique case (opcode)
               bmcu_pkg::OP_WM: begin
                  mem_we = 1'b1;
               end
               bmcu_pkg::OP_RM: begin
                  // Operand read is issued now; the byte lands next cycle.
                  mem_ra       = mem_index(operand);
                  state_in     = bmcu_pkg::S_DATA;
                  rsp_valid_in = 1'b0;
               end
               bmcu_pkg::OP_BR: begin
                  pc_in = operand;
               end
               bmcu_pkg::OP_RIO: begin
                  iobr_in = io_rd;
               end
               bmcu_pkg::OP_WIO: begin
                  io_we = 1'b1;
               end
               bmcu_pkg::OP_WB: begin
                  mbr_in = operand[7:0];
               end
               bmcu_pkg::OP_WIB: begin
                  iobr_in = operand[7:0];
               end
               bmcu_pkg::OP_EOP: begin
                  halted_in     = 1'b1;
                  rsp_in.status = bmcu_pkg::STAT_END;
               end
               default: begin
                  halted_in     = 1'b1;
                  rsp_in.status = bmcu_pkg::STAT_BADOP;
               end
            endcase
            rsp_in.pc_next    = pc_in;
            rsp_in.instr_word = fetch_word;
            rsp_in.mbr_value  = mbr_in;
            rsp_in.iobr_value = iobr_in;
            rsp_in.io_read    = 8'd0;
         end
         bmcu_pkg::S_DATA: begin
            mbr_in            = rd_a_ff;
            rsp_in.status     = bmcu_pkg::STAT_EXEC;
            rsp_in.pc_next    = pc_ff;
            rsp_in.instr_word = word_ff;
            rsp_in.mbr_value  = rd_a_ff;
            rsp_in.iobr_value = iobr_ff;
            rsp_in.io_read    = 8'd0;
            rsp_valid_in      = 1'b1;
            state_in          = bmcu_pkg::S_ACCEPT;
         end
         default: begin
            state_in = bmcu_pkg::S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmcu_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         pc_ff        <= '0;
         mbr_ff       <= 8'd0;
         iobr_ff      <= 8'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pc_ff        <= pc_in;
         mbr_ff       <= mbr_in;
         iobr_ff      <= iobr_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= mem[mem_ra];
      rd_b_ff <= mem[mem_rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IO_DEPTH; i++) begin
            io_ff[i] <= 8'd0;
         end
      end else if (io_we) begin
         io_ff[io_wa] <= io_wd;
      end
   end

endmodule
